// File: rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker package
// Shared widths, register indexes, beat payloads and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // Field widths.
   localparam int POWER_W    = 16;   // measured power, 1/16 W
   localparam int VOLT_W     = 15;   // set-point voltage, 1/64 V
   localparam int STEP_W     = 11;   // step size, 1/64 V
   localparam int TOL_W      = 16;   // tolerance, Q0.16 S
   localparam int MOVE_W     = 2;
   localparam int AMPS_W     = 34;   // current (P << 18) / V
   localparam int COND_W     = 24;   // saturated Q8.16 conductance terms
   localparam int AMPS_SHIFT = 18;
   localparam int COND_SHIFT = 6;    // multiplication by 64

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALGORITHM   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VOLTAGE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VOLTAGE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 3'd4;

   // Reset values.
   localparam logic              RST_ALGORITHM   = 1'b0;
   localparam logic [STEP_W-1:0] RST_STEP_SIZE   = 11'd64;
   localparam logic [VOLT_W-1:0] RST_MIN_VOLTAGE = 15'd6400;
   localparam logic [VOLT_W-1:0] RST_MAX_VOLTAGE = 15'd19200;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 16'd655;
   localparam logic [VOLT_W-1:0] RST_SET_POINT   = 15'd12800;

   // Algorithm select.
   localparam logic ALG_PERTURB = 1'b0;

   // Move codes reported on the result beat.
   localparam logic [MOVE_W-1:0] MOVE_HOLD = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_UP   = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_DOWN = 2'd2;

   // Shared divider: two restoring steps per cycle.
   localparam int DIV_RADIX_BITS = 2;
   localparam int AMPS_CYCLES    = AMPS_W / DIV_RADIX_BITS;
   localparam int COND_CYCLES    = COND_W / DIV_RADIX_BITS;
   localparam int CNT_W          = $clog2(AMPS_CYCLES + 1);

   localparam logic signed [COND_W-1:0] COND_MAX = 24'sh7FFFFF;
   localparam logic signed [COND_W-1:0] COND_MIN = 24'sh800000;

   typedef enum logic [1:0] {
      DIV_IPREV = 2'd0,   // current at the previous set-point
      DIV_INOW  = 2'd1,   // current at the present set-point
      DIV_GINC  = 2'd2,   // incremental conductance dI/dV
      DIV_GCOND = 2'd3    // conductance I/V
   } div_op_type;

   typedef struct packed {
      logic [POWER_W-1:0] measured_power;
   } mvt_req_type;

   typedef struct packed {
      logic [VOLT_W-1:0] set_point_out;
      logic [MOVE_W-1:0] move;
      logic              clamped;
   } mvt_rsp_type;

   typedef struct packed {
      logic       take_req;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic       decide;
      logic       commit;
      div_op_type op;
   } mvt_cmd_type;

   typedef struct packed {
      logic algorithm;
   } mvt_stat_type;

endpackage

// File: rtl/mvt_stream_if.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker stream interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface mvt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mvt_datapath.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker datapath
// Configuration registers, tracker state, shared radix-4 divider, decision
// logic and the step-and-clamp result register.
// ----------------------------------------------------------------------------
module mvt_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [mvt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mvt_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  mvt_pkg::mvt_req_type             req_payload,
   input  mvt_pkg::mvt_cmd_type             cmd,
   output mvt_pkg::mvt_stat_type            stat,
   output mvt_pkg::mvt_rsp_type             rsp_payload
);

   // Configuration registers.
   logic                             alg_ff;
   logic [mvt_pkg::STEP_W-1:0]       step_ff;
   logic [mvt_pkg::VOLT_W-1:0]       minv_ff;
   logic [mvt_pkg::VOLT_W-1:0]       maxv_ff;
   logic [mvt_pkg::TOL_W-1:0]        tol_ff;

   // Tracker state.
   logic [mvt_pkg::VOLT_W-1:0]       sp_ff;
   logic [mvt_pkg::VOLT_W-1:0]       lastv_ff;
   logic [mvt_pkg::POWER_W-1:0]      lastp_ff;
   logic [mvt_pkg::AMPS_W-1:0]       ip_ff;

   // Item working registers.
   logic [mvt_pkg::POWER_W-1:0]      p_ff;
   logic [mvt_pkg::AMPS_W-1:0]       i_ff;
   logic signed [mvt_pkg::COND_W-1:0] ginc_ff;
   logic signed [mvt_pkg::COND_W-1:0] g_ff;
   logic [mvt_pkg::MOVE_W-1:0]       move_ff;
   mvt_pkg::mvt_rsp_type             rsp_ff;

   // Divider registers.
   logic [mvt_pkg::VOLT_W-1:0]       rem_ff, rem_in;
   logic [mvt_pkg::AMPS_W-1:0]       sh_ff, sh_in;
   logic [mvt_pkg::VOLT_W-1:0]       dsor_ff, dsor_in;
   logic                             zero_ff, zero_in;
   logic                             ovf_ff, ovf_in;
   logic                             neg_ff, neg_in;

   // Load operands.
   logic [mvt_pkg::AMPS_W:0]         di;
   logic [mvt_pkg::AMPS_W-1:0]       mag_di;
   logic [mvt_pkg::VOLT_W:0]         dv;
   logic [mvt_pkg::VOLT_W-1:0]       mag_dv;

   // Step, store and decision values.
   logic [mvt_pkg::VOLT_W-1:0]       step_rem;
   logic [mvt_pkg::AMPS_W-1:0]       step_sh;
   logic [mvt_pkg::COND_W-1:0]       quo;
   logic signed [mvt_pkg::COND_W-1:0] ginc_in;
   logic signed [mvt_pkg::COND_W-1:0] g_in;
   logic [mvt_pkg::COND_W:0]         sum;
   logic [mvt_pkg::COND_W:0]         mag_sum;
   logic [mvt_pkg::MOVE_W-1:0]       move_po;
   logic [mvt_pkg::MOVE_W-1:0]       move_ic;
   logic [mvt_pkg::VOLT_W+1:0]       stepped;
   logic [mvt_pkg::VOLT_W+1:0]       low_clamped;
   logic [mvt_pkg::VOLT_W+1:0]       result;

   assign stat.algorithm = alg_ff;
   assign rsp_payload    = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff  <= mvt_pkg::RST_ALGORITHM;
         step_ff <= mvt_pkg::RST_STEP_SIZE;
         minv_ff <= mvt_pkg::RST_MIN_VOLTAGE;
         maxv_ff <= mvt_pkg::RST_MAX_VOLTAGE;
         tol_ff  <= mvt_pkg::RST_TOLERANCE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mvt_pkg::CSR_ALGORITHM:   alg_ff  <= csr_write_data[0];
            mvt_pkg::CSR_STEP_SIZE:   step_ff <= csr_write_data[mvt_pkg::STEP_W-1:0];
            mvt_pkg::CSR_MIN_VOLTAGE: minv_ff <= csr_write_data[mvt_pkg::VOLT_W-1:0];
            mvt_pkg::CSR_MAX_VOLTAGE: maxv_ff <= csr_write_data[mvt_pkg::VOLT_W-1:0];
            mvt_pkg::CSR_TOLERANCE:   tol_ff  <= csr_write_data[mvt_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Differences for the incremental conductance term, taken as sign and
   // magnitude so the divider only ever sees unsigned operands.
   always_comb begin
      di     = {1'b0, i_ff} - {1'b0, ip_ff};
      mag_di = di[mvt_pkg::AMPS_W] ? mvt_pkg::AMPS_W'((mvt_pkg::AMPS_W+1)'(0) - di)
                                   : di[mvt_pkg::AMPS_W-1:0];
      dv     = {1'b0, sp_ff} - {1'b0, lastv_ff};
      mag_dv = dv[mvt_pkg::VOLT_W] ? mvt_pkg::VOLT_W'((mvt_pkg::VOLT_W+1)'(0) - dv)
                                   : dv[mvt_pkg::VOLT_W-1:0];
   end

   // Divider load. The 40-bit conductance dividends are split into the top
   // sixteen bits, which seed the remainder (or flag an oversized quotient),
   // and the low 24 bits, which are shifted through one quotient bit at a time.
   always_comb begin
      rem_in  = '0;
      sh_in   = '0;
      dsor_in = sp_ff;
      zero_in = 1'b0;
      ovf_in  = 1'b0;
      neg_in  = 1'b0;
      unique case (cmd.op)
         mvt_pkg::DIV_IPREV: begin
            sh_in   = {lastp_ff, mvt_pkg::AMPS_SHIFT'(0)};
            dsor_in = lastv_ff;
            zero_in = (lastv_ff == '0);
         end
         mvt_pkg::DIV_INOW: begin
            sh_in   = {p_ff, mvt_pkg::AMPS_SHIFT'(0)};
            zero_in = (sp_ff == '0);
         end
         mvt_pkg::DIV_GINC: begin
            rem_in  = mag_di[mvt_pkg::AMPS_W-2:mvt_pkg::AMPS_SHIFT];
            sh_in   = {mag_di[mvt_pkg::AMPS_SHIFT-1:0], mvt_pkg::COND_SHIFT'(0),
                       (mvt_pkg::AMPS_W-mvt_pkg::COND_W)'(0)};
            dsor_in = mag_dv;
            zero_in = (mag_dv == '0);
            ovf_in  = (mag_di[mvt_pkg::AMPS_W-1:mvt_pkg::AMPS_SHIFT] >= {1'b0, mag_dv});
            neg_in  = di[mvt_pkg::AMPS_W] ^ dv[mvt_pkg::VOLT_W];
         end
         mvt_pkg::DIV_GCOND: begin
            rem_in  = i_ff[mvt_pkg::AMPS_W-2:mvt_pkg::AMPS_SHIFT];
            sh_in   = {i_ff[mvt_pkg::AMPS_SHIFT-1:0], mvt_pkg::COND_SHIFT'(0),
                       (mvt_pkg::AMPS_W-mvt_pkg::COND_W)'(0)};
            zero_in = (sp_ff == '0);
            ovf_in  = (i_ff[mvt_pkg::AMPS_W-1:mvt_pkg::AMPS_SHIFT] >= {1'b0, sp_ff});
         end
         default: ;
      endcase
   end

   // Two restoring division steps.
   always_comb begin
      logic [mvt_pkg::VOLT_W:0] trial;
      step_rem = rem_ff;
      step_sh  = sh_ff;
      for (int k = 0; k < mvt_pkg::DIV_RADIX_BITS; k++) begin
         trial = {step_rem, step_sh[mvt_pkg::AMPS_W-1]};
         if (trial >= {1'b0, dsor_ff}) begin
            step_rem = mvt_pkg::VOLT_W'(trial - {1'b0, dsor_ff});
            step_sh  = {step_sh[mvt_pkg::AMPS_W-2:0], 1'b1};
         end else begin
            step_rem = trial[mvt_pkg::VOLT_W-1:0];
            step_sh  = {step_sh[mvt_pkg::AMPS_W-2:0], 1'b0};
         end
      end
   end

   // Saturation of the finished conductance quotients to signed Q8.16.
   always_comb begin
      quo = sh_ff[mvt_pkg::COND_W-1:0];
      if (zero_ff) begin
         ginc_in = '0;
      end else if (!neg_ff) begin
         ginc_in = (ovf_ff || quo[mvt_pkg::COND_W-1]) ? mvt_pkg::COND_MAX : $signed(quo);
      end else if (ovf_ff || (quo[mvt_pkg::COND_W-1] && (quo[mvt_pkg::COND_W-2:0] != '0))) begin
         ginc_in = mvt_pkg::COND_MIN;
      end else begin
         ginc_in = $signed(mvt_pkg::COND_W'(0) - quo);
      end
      if (zero_ff) begin
         g_in = '0;
      end else begin
         g_in = (ovf_ff || quo[mvt_pkg::COND_W-1]) ? mvt_pkg::COND_MAX : $signed(quo);
      end
   end

   // Decision.
   always_comb begin
      logic rose;
      logic went_up;
      rose    = p_ff > lastp_ff;
      went_up = sp_ff > lastv_ff;
      move_po = (rose == went_up) ? mvt_pkg::MOVE_UP : mvt_pkg::MOVE_DOWN;

      sum     = {ginc_ff[mvt_pkg::COND_W-1], ginc_ff} + {g_ff[mvt_pkg::COND_W-1], g_ff};
      mag_sum = sum[mvt_pkg::COND_W] ? ((mvt_pkg::COND_W+1)'(0) - sum) : sum;
      if (mag_sum < {(mvt_pkg::COND_W+1-mvt_pkg::TOL_W)'(0), tol_ff}) begin
         move_ic = mvt_pkg::MOVE_HOLD;
      end else if (!sum[mvt_pkg::COND_W] && (sum != '0)) begin
         move_ic = mvt_pkg::MOVE_UP;
      end else begin
         move_ic = mvt_pkg::MOVE_DOWN;
      end
   end

   // Step and clamp: lower limit first, upper limit last.
   always_comb begin
      logic [mvt_pkg::VOLT_W+1:0] sp_ext;
      logic [mvt_pkg::VOLT_W+1:0] step_ext;
      logic [mvt_pkg::VOLT_W+1:0] min_ext;
      logic [mvt_pkg::VOLT_W+1:0] max_ext;
      sp_ext   = {2'b00, sp_ff};
      step_ext = {(mvt_pkg::VOLT_W+2-mvt_pkg::STEP_W)'(0), step_ff};
      min_ext  = {2'b00, minv_ff};
      max_ext  = {2'b00, maxv_ff};
      case (move_ff)
         mvt_pkg::MOVE_UP:   stepped = sp_ext + step_ext;
         mvt_pkg::MOVE_DOWN: stepped = sp_ext - step_ext;
         default:            stepped = sp_ext;
      endcase
      low_clamped = ($signed(stepped) < $signed(min_ext)) ? min_ext : stepped;
      result      = ($signed(low_clamped) > $signed(max_ext)) ? max_ext : low_clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= mvt_pkg::RST_SET_POINT;
         lastv_ff <= '0;
         lastp_ff <= '0;
         ip_ff    <= '0;
      end else begin
         if (cmd.div_store && (cmd.op == mvt_pkg::DIV_IPREV)) begin
            ip_ff <= zero_ff ? '0 : sh_ff;
         end else if (cmd.commit && (alg_ff != mvt_pkg::ALG_PERTURB)) begin
            ip_ff <= i_ff;
         end
         if (cmd.commit) begin
            sp_ff    <= result[mvt_pkg::VOLT_W-1:0];
            lastv_ff <= sp_ff;
            lastp_ff <= p_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         p_ff <= req_payload.measured_power;
      end
      if (cmd.div_load) begin
         rem_ff  <= rem_in;
         sh_ff   <= sh_in;
         dsor_ff <= dsor_in;
         zero_ff <= zero_in;
         ovf_ff  <= ovf_in;
         neg_ff  <= neg_in;
      end else if (cmd.div_step) begin
         rem_ff <= step_rem;
         sh_ff  <= step_sh;
      end
      if (cmd.div_store) begin
         case (cmd.op)
            mvt_pkg::DIV_INOW:  i_ff    <= zero_ff ? '0 : sh_ff;
            mvt_pkg::DIV_GINC:  ginc_ff <= ginc_in;
            mvt_pkg::DIV_GCOND: g_ff    <= g_in;
            default: ;
         endcase
      end
      if (cmd.decide) begin
         move_ff <= (alg_ff == mvt_pkg::ALG_PERTURB) ? move_po : move_ic;
      end
      if (cmd.commit) begin
         rsp_ff.set_point_out <= result[mvt_pkg::VOLT_W-1:0];
         rsp_ff.move          <= move_ff;
         rsp_ff.clamped       <= (result != stepped);
      end
   end

endmodule

// File: rtl/mvt_ctrl.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker controller
// Sequences the divisions, decision and commit of one item and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module mvt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mvt_pkg::mvt_stat_type  stat,
   output mvt_pkg::mvt_cmd_type   cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_RUN    = 6'b000100,
      ST_STORE  = 6'b001000,
      ST_DECIDE = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   mvt_pkg::div_op_type         op_ff, op_in;
   logic [mvt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        ip_valid_ff, ip_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      ip_valid_in  = ip_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               op_in        = ip_valid_ff ? mvt_pkg::DIV_INOW : mvt_pkg::DIV_IPREV;
               state_in     = (stat.algorithm == mvt_pkg::ALG_PERTURB) ? ST_DECIDE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            if ((op_ff == mvt_pkg::DIV_IPREV) || (op_ff == mvt_pkg::DIV_INOW)) begin
               cnt_in = mvt_pkg::CNT_W'(mvt_pkg::AMPS_CYCLES);
            end else begin
               cnt_in = mvt_pkg::CNT_W'(mvt_pkg::COND_CYCLES);
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - mvt_pkg::CNT_W'(1);
            if (cnt_ff == mvt_pkg::CNT_W'(1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            state_in      = ST_LOAD;
            case (op_ff)
               mvt_pkg::DIV_IPREV: op_in = mvt_pkg::DIV_INOW;
               mvt_pkg::DIV_INOW:  op_in = mvt_pkg::DIV_GINC;
               mvt_pkg::DIV_GINC:  op_in = mvt_pkg::DIV_GCOND;
               default:            state_in = ST_DECIDE;
            endcase
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // The result register is overwritten only once its beat has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               ip_valid_in  = (stat.algorithm != mvt_pkg::ALG_PERTURB);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= mvt_pkg::DIV_INOW;
         cnt_ff       <= '0;
         ip_valid_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         ip_valid_ff  <= ip_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/mppt_voltage_tracker_top.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker
// Perturb-and-observe or incremental conductance tracking of the panel
// set-point voltage, one result beat for each measured-power beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_if    in         valid/ready            measured_power
//  rsp_if    out        valid/ready            set_point_out, move, clamped
//  csr_*     in         write enable only      index 0..4, data 16 bits
//
//  Under perturb-and-observe the accepted beat goes straight to the decide and
//  commit states; under incremental conductance the divider first works out the
//  present current, dI/dV and I/V, and before these the previous current when
//  the last update was made by perturb-and-observe. Each division runs on the
//  shared radix-4 restoring divider (two quotient bits a cycle).
//  One item is in work at a time; a new beat is accepted while the last result
//  waits on rsp_if, and a stalled result holds the commit of the next item.
//  Reset is synchronous; ready is low during reset and rises once it falls.
// ----------------------------------------------------------------------------
module mppt_voltage_tracker_top (
   input  logic                             clock,
   input  logic                             reset,
   mvt_stream_if.sink                       req_if,
   mvt_stream_if.source                     rsp_if,
   input  logic                             csr_write_en,
   input  logic [mvt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mvt_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   mvt_pkg::mvt_cmd_type  cmd;
   mvt_pkg::mvt_stat_type stat;
   mvt_pkg::mvt_req_type  req_payload;
   mvt_pkg::mvt_rsp_type  rsp_payload;

   assign req_payload    = req_if.payload;
   assign rsp_if.payload = rsp_payload;

   mvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mvt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_payload    (req_payload),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_payload    (rsp_payload)
   );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// MPPT voltage tracker testbench
// Drives measured-power beats into the tracker under both algorithms and a
// range of register settings, predicts every set-point update with its own
// tracking model and checks each result beat field by field, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ALG_INC_COND     = ~mvt_pkg::ALG_PERTURB;
   localparam int   SETTLE_CYCLES    = 100;
   localparam int   LONG_HOLD_CYCLES = 300;
   localparam int   WATCHDOG_LIMIT   = 5000;
   localparam int   RANDOM_PHASES    = 8;
   localparam int   BEATS_PER_PHASE  = 85;

   typedef struct {
      bit                          on_curve;   // power taken from the panel curve when offered
      logic [mvt_pkg::POWER_W-1:0] power;
   } power_beat_type;

   logic clock;
   logic reset;
   logic                            csr_write_en;
   logic [mvt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mvt_pkg::CSR_DATA_W-1:0]  csr_write_data;

   mvt_stream_if #(.payload_type(mvt_pkg::mvt_req_type)) req_chan ();
   mvt_stream_if #(.payload_type(mvt_pkg::mvt_rsp_type)) rsp_chan ();

   mppt_voltage_tracker_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_chan),
      .rsp_if         (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Tracker model: registers and state as the block should hold them.
   logic                        cfg_algorithm = mvt_pkg::RST_ALGORITHM;
   logic [mvt_pkg::STEP_W-1:0]  cfg_step      = mvt_pkg::RST_STEP_SIZE;
   logic [mvt_pkg::VOLT_W-1:0]  cfg_min_volt  = mvt_pkg::RST_MIN_VOLTAGE;
   logic [mvt_pkg::VOLT_W-1:0]  cfg_max_volt  = mvt_pkg::RST_MAX_VOLTAGE;
   logic [mvt_pkg::TOL_W-1:0]   cfg_tolerance = mvt_pkg::RST_TOLERANCE;
   logic [mvt_pkg::VOLT_W-1:0]  model_set_point  = mvt_pkg::RST_SET_POINT;
   logic [mvt_pkg::VOLT_W-1:0]  model_last_volt  = '0;
   logic [mvt_pkg::POWER_W-1:0] model_last_power = '0;

   power_beat_type       pending_beats[$];
   mvt_pkg::mvt_rsp_type predicted_moves[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int long_hold_requests = 0;
   int long_hold_served   = 0;
   int stall_left         = 0;
   int quiet_cycles       = 0;

   // Panel curve used for well-formed tracking runs.
   longint curve_peak_volt  = 12800;
   longint curve_peak_power = 40000;
   int     curve_shift      = 8;
   int     curve_noise      = 0;

   int error_count    = 0;
   int beats_in       = 0;
   int inc_cond_beats = 0;
   int results_seen   = 0;
   int holds = 0, ups = 0, downs = 0, clamps = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic longint clip_q816(input longint x);
      if (x > longint'(mvt_pkg::COND_MAX)) return longint'(mvt_pkg::COND_MAX);
      if (x < longint'(mvt_pkg::COND_MIN)) return longint'(mvt_pkg::COND_MIN);
      return x;
   endfunction

   // Works out the next set-point from one power measurement and advances the
   // model state exactly as the block does.
   function automatic mvt_pkg::mvt_rsp_type track_power(
      input logic [mvt_pkg::POWER_W-1:0] pw);
      logic [mvt_pkg::VOLT_W-1:0] v;
      longint i_now, i_prev, dv, g_inc, g_cond, sum;
      int stepped, bounded;
      mvt_pkg::mvt_rsp_type r;
      v = model_set_point;
      if (cfg_algorithm == mvt_pkg::ALG_PERTURB) begin
         // A voltage that did not rise counts as a downward last move.
         if (pw > model_last_power)
            r.move = (v > model_last_volt) ? mvt_pkg::MOVE_UP : mvt_pkg::MOVE_DOWN;
         else
            r.move = (v > model_last_volt) ? mvt_pkg::MOVE_DOWN : mvt_pkg::MOVE_UP;
      end else begin
         // Any quotient with a zero divisor is taken as zero.
         i_now  = (v == 0) ? 0 : (longint'(pw) <<< mvt_pkg::AMPS_SHIFT) / longint'(v);
         i_prev = (model_last_volt == 0) ? 0 :
                  (longint'(model_last_power) <<< mvt_pkg::AMPS_SHIFT) /
                  longint'(model_last_volt);
         dv     = longint'(v) - longint'(model_last_volt);
         g_inc  = (dv == 0) ? 0 :
                  clip_q816(((i_now - i_prev) <<< mvt_pkg::COND_SHIFT) / dv);
         g_cond = (v == 0) ? 0 : clip_q816((i_now <<< mvt_pkg::COND_SHIFT) / longint'(v));
         sum    = g_inc + g_cond;
         if (((sum < 0) ? -sum : sum) < longint'(cfg_tolerance)) r.move = mvt_pkg::MOVE_HOLD;
         else r.move = (sum > 0) ? mvt_pkg::MOVE_UP : mvt_pkg::MOVE_DOWN;
      end
      stepped = int'(v);
      if (r.move == mvt_pkg::MOVE_UP)   stepped += int'(cfg_step);
      if (r.move == mvt_pkg::MOVE_DOWN) stepped -= int'(cfg_step);
      // Lower limit first, upper last, so crossed limits settle on the upper.
      bounded = stepped;
      if (bounded < int'(cfg_min_volt)) bounded = int'(cfg_min_volt);
      if (bounded > int'(cfg_max_volt)) bounded = int'(cfg_max_volt);
      model_last_power = pw;
      model_last_volt  = v;
      model_set_point  = bounded[mvt_pkg::VOLT_W-1:0];
      r.set_point_out  = bounded[mvt_pkg::VOLT_W-1:0];
      r.clamped        = (bounded != stepped);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Request driver: a new beat is chosen only once the previous one is taken.
   always @(posedge clock) begin : power_driver
      bit               busy;
      power_beat_type   beat;
      longint           offset, pw;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= '0;
      end else begin
         busy = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            if (cfg_algorithm != mvt_pkg::ALG_PERTURB) inc_cond_beats++;
            predicted_moves.push_back(track_power(req_chan.payload.measured_power));
            beats_in++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               beat = pending_beats.pop_front();
               if (beat.on_curve) begin
                  // Set-point of the beat offered now is already in the model.
                  offset = longint'(model_set_point) - curve_peak_volt;
                  if (offset < 0) offset = -offset;
                  pw = curve_peak_power - ((offset * offset) >>> curve_shift)
                       + longint'($urandom_range(0, curve_noise));
                  if (pw < 0) pw = 0;
                  if (pw > 65535) pw = 65535;
                  beat.power = pw[mvt_pkg::POWER_W-1:0];
               end
               req_chan.valid                  <= 1'b1;
               req_chan.payload.measured_power <= beat.power;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      mvt_pkg::mvt_rsp_type want, got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            results_seen++;
            if (predicted_moves.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
            end else begin
               want = predicted_moves.pop_front();
               if (got.set_point_out !== want.set_point_out)
                  report_mismatch($sformatf("beat %0d set_point_out %0d, expected %0d",
                                  results_seen, got.set_point_out, want.set_point_out));
               if (got.move !== want.move)
                  report_mismatch($sformatf("beat %0d move %0d, expected %0d",
                                  results_seen, got.move, want.move));
               if (got.clamped !== want.clamped)
                  report_mismatch($sformatf("beat %0d clamped %0b, expected %0b",
                                  results_seen, got.clamped, want.clamped));
               case (want.move)
                  mvt_pkg::MOVE_HOLD: holds++;
                  mvt_pkg::MOVE_UP:   ups++;
                  default:            downs++;
               endcase
               if (want.clamped) clamps++;
            end
         end
         if (long_hold_requests != long_hold_served) begin
            long_hold_served = long_hold_requests;
            stall_left       = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("mppt_voltage_tracker_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_power(input logic [mvt_pkg::POWER_W-1:0] pw);
      pending_beats.push_back('{on_curve: 1'b0, power: pw});
   endtask

   // Waits until every beat is sent and answered, then lets the block settle.
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_chan.valid || predicted_moves.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tracker_reg(input logic [mvt_pkg::CSR_INDEX_W-1:0] idx,
                                    input logic [mvt_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         mvt_pkg::CSR_ALGORITHM:   cfg_algorithm = data[0];
         mvt_pkg::CSR_STEP_SIZE:   cfg_step      = data[mvt_pkg::STEP_W-1:0];
         mvt_pkg::CSR_MIN_VOLTAGE: cfg_min_volt  = data[mvt_pkg::VOLT_W-1:0];
         mvt_pkg::CSR_MAX_VOLTAGE: cfg_max_volt  = data[mvt_pkg::VOLT_W-1:0];
         mvt_pkg::CSR_TOLERANCE:   cfg_tolerance = data[mvt_pkg::TOL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic program_tracker(input logic alg, input logic [mvt_pkg::STEP_W-1:0] step,
                                  input logic [mvt_pkg::VOLT_W-1:0] vmin,
                                  input logic [mvt_pkg::VOLT_W-1:0] vmax,
                                  input logic [mvt_pkg::TOL_W-1:0] tol);
      wait_drained();
      write_tracker_reg(mvt_pkg::CSR_ALGORITHM, mvt_pkg::CSR_DATA_W'(alg));
      write_tracker_reg(mvt_pkg::CSR_STEP_SIZE, mvt_pkg::CSR_DATA_W'(step));
      write_tracker_reg(mvt_pkg::CSR_MIN_VOLTAGE, mvt_pkg::CSR_DATA_W'(vmin));
      write_tracker_reg(mvt_pkg::CSR_MAX_VOLTAGE, mvt_pkg::CSR_DATA_W'(vmax));
      write_tracker_reg(mvt_pkg::CSR_TOLERANCE, mvt_pkg::CSR_DATA_W'(tol));
   endtask

   initial begin : stimulus
      logic                        alg;
      logic [mvt_pkg::STEP_W-1:0]  step;
      logic [mvt_pkg::VOLT_W-1:0]  vmin, vmax;
      logic [mvt_pkg::TOL_W-1:0]   tol;
      int                          pick;

      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first update from zeroed history, rise, equal, fall.
      offer_power(16'd0);
      offer_power(16'hFFFF);
      offer_power(16'hFFFF);
      offer_power(16'd1);
      // Incremental conductance straight after perturb-and-observe history.
      program_tracker(ALG_INC_COND, mvt_pkg::RST_STEP_SIZE, mvt_pkg::RST_MIN_VOLTAGE,
                      mvt_pkg::RST_MAX_VOLTAGE, mvt_pkg::RST_TOLERANCE);
      offer_power(16'd0);
      offer_power(16'hFFFF);
      offer_power(16'd30000);
      // A zero step leaves the voltage unchanged, so the second beat sees a zero dV; no tolerance.
      program_tracker(ALG_INC_COND, 11'd0, mvt_pkg::RST_MIN_VOLTAGE,
                      mvt_pkg::RST_MAX_VOLTAGE, 16'd0);
      offer_power(16'd40000);
      offer_power(16'd40000);
      // Pin the set-point at zero volts, then track with zero divisors.
      program_tracker(mvt_pkg::ALG_PERTURB, 11'd2047, 15'd0, 15'd0, 16'hFFFF);
      offer_power(16'd100);
      program_tracker(ALG_INC_COND, 11'd2047, 15'd0, 15'd0, 16'hFFFF);
      offer_power(16'd500);
      offer_power(16'd500);
      // Step below zero volts, clamped back to the lower limit.
      program_tracker(mvt_pkg::ALG_PERTURB, 11'd2047, 15'd0, 15'h7FFF,
                      mvt_pkg::RST_TOLERANCE);
      offer_power(16'd1000);
      // Pin at full scale, then step beyond it.
      program_tracker(mvt_pkg::ALG_PERTURB, 11'd2047, 15'h7FFF, 15'h7FFF,
                      mvt_pkg::RST_TOLERANCE);
      offer_power(16'd0);
      program_tracker(mvt_pkg::ALG_PERTURB, 11'd2047, 15'd0, 15'h7FFF,
                      mvt_pkg::RST_TOLERANCE);
      offer_power(16'hFFFF);
      // Crossed limits settle on the upper one.
      program_tracker(mvt_pkg::ALG_PERTURB, 11'd1, 15'd20000, 15'd10000,
                      mvt_pkg::RST_TOLERANCE);
      offer_power(16'd7);
      offer_power(16'd7);
      // Wide tolerance band: the held set-point still goes through the clamp.
      program_tracker(ALG_INC_COND, mvt_pkg::RST_STEP_SIZE, mvt_pkg::RST_MIN_VOLTAGE,
                      mvt_pkg::RST_MAX_VOLTAGE, 16'hFFFF);
      offer_power(16'd3000);
      offer_power(16'd3000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         alg = 1'($urandom_range(1));
         case ($urandom_range(9))
            0:       step = 11'd0;
            1:       step = 11'd1;
            2:       step = 11'd1024;
            3:       step = 11'd2047;
            default: step = mvt_pkg::STEP_W'($urandom_range(1, 128));
         endcase
         case ($urandom_range(7))
            0: begin vmin = 15'd0; vmax = 15'h7FFF; end
            1: begin
               vmin = mvt_pkg::VOLT_W'($urandom_range(16384, 32767));
               vmax = mvt_pkg::VOLT_W'($urandom_range(0, 16383));
            end
            2: begin vmin = mvt_pkg::VOLT_W'($urandom_range(0, 32767)); vmax = vmin; end
            default: begin
               vmin = mvt_pkg::VOLT_W'($urandom_range(0, 16000));
               vmax = vmin + mvt_pkg::VOLT_W'($urandom_range(200, 16767));
            end
         endcase
         case ($urandom_range(5))
            0:       tol = 16'd0;
            1:       tol = 16'hFFFF;
            2:       tol = mvt_pkg::TOL_W'($urandom_range(0, 65535));
            default: tol = mvt_pkg::TOL_W'($urandom_range(100, 5000));
         endcase
         if (phase == 0) begin
            alg = ALG_INC_COND;
            tol = 16'hFFFF;
         end
         if (phase == 1) begin
            alg  = mvt_pkg::ALG_PERTURB;
            step = 11'd1024;
         end
         program_tracker(alg, step, vmin, vmax, tol);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
         endcase
         curve_peak_volt  = (vmin <= vmax) ? $urandom_range(vmin, vmax) : $urandom_range(0, 32767);
         curve_peak_power = $urandom_range(8000, 65535);
         curve_shift      = $urandom_range(4, 12);
         curve_noise      = $urandom_range(0, 63);

         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // Once the sender stops halfway and waits for every result.
            if (phase == 5 && n == BEATS_PER_PHASE / 2) wait_drained();
            pick = $urandom_range(99);
            if (pick < 75)      pending_beats.push_back('{on_curve: 1'b1, power: '0});
            else if (pick < 92) offer_power(mvt_pkg::POWER_W'($urandom_range(0, 65535)));
            else                offer_power(($urandom_range(1) != 0) ? 16'hFFFF : 16'd0);
         end
         // Receiver holds off while the sender keeps offering beats.
         if (phase == 0 || phase == 4) long_hold_requests <= long_hold_requests + 1;
      end

      wait_drained();
      $display("Covered %0d power beats (%0d by incremental conductance) and %0d results",
               beats_in, inc_cond_beats, results_seen);
      $display("Moves seen: hold %0d, up %0d, down %0d, clamped %0d; mismatches %0d",
               holds, ups, downs, clamps, error_count);
      if (error_count == 0) begin
         $display("mppt_voltage_tracker_top verification clean");
      end else begin
         $display("mppt_voltage_tracker_top verification failed");
      end
      $finish;
   end

endmodule
